// File: hdl/mfr_pkg.sv
// Shared types and constants for the MQTT frame receiver.
// No dependencies; imported by every module of the block.
package mfr_pkg;

    // Input item and result item
    typedef struct packed {
        logic       func;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [7:0]  byte_out;
        logic [3:0]  frame_type;
        logic [3:0]  frame_flags;
        logic [27:0] body_length;
        logic        frame_end;
        logic [2:0]  status;
        logic [1:0]  link_state;
    } t_out_item;

    // Input function codes
    localparam logic FUNC_BYTE    = 1'b0;
    localparam logic FUNC_RESTART = 1'b1;

    // Classified operation passed from front end to engine
    typedef enum logic [0:0] {
        OP_BYTE    = 1'b0,
        OP_RESTART = 1'b1
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
    } t_op_item;

    // Decoupling queue size
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // Event codes
    localparam logic [1:0] EV_HEADER  = 2'd0;
    localparam logic [1:0] EV_BODY    = 2'd1;
    localparam logic [1:0] EV_DROP    = 2'd2;
    localparam logic [1:0] EV_RESTART = 2'd3;

    // Status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_STATE  = 3'd1;
    localparam logic [2:0] ST_UNEXPECTED = 3'd2;
    localparam logic [2:0] ST_REFUSED    = 3'd3;
    localparam logic [2:0] ST_MALFORMED  = 3'd4;

    // Reported link state codes
    localparam logic [1:0] LS_WAIT = 2'd0;
    localparam logic [1:0] LS_CONN = 2'd1;
    localparam logic [1:0] LS_ERR  = 2'd2;

    // Control packet types
    localparam logic [3:0] PKT_CONNACK  = 4'd2;
    localparam logic [3:0] PKT_PUBLISH  = 4'd3;
    localparam logic [3:0] PKT_PUBACK   = 4'd4;
    localparam logic [3:0] PKT_PUBREC   = 4'd5;
    localparam logic [3:0] PKT_PUBREL   = 4'd6;
    localparam logic [3:0] PKT_PUBCOMP  = 4'd7;
    localparam logic [3:0] PKT_SUBACK   = 4'd9;
    localparam logic [3:0] PKT_UNSUBACK = 4'd11;
    localparam logic [3:0] PKT_PINGRESP = 4'd13;

    // Byte field masks
    localparam logic [7:0] LEN_DATA_MASK = 8'h7F;
    localparam logic [7:0] LEN_MORE_BIT  = 8'h80;
    localparam logic [3:0] NIBBLE_MASK   = 4'h0F;

endpackage

// File: hdl/mfr_front.sv
// Front end of the MQTT frame receiver: input register and classification.
// Depends on mfr_pkg; feeds mfr_queue.
module mfr_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  mfr_pkg::t_in_item i_in_data,
    output logic              o_push,
    output mfr_pkg::t_op_item o_push_data,
    input  logic              i_queue_full
);
    import mfr_pkg::*;

    logic     r_valid;
    t_op_item r_item;
    t_op_item n_item;
    logic     n_valid;

    // Classify the incoming item; restart carries no byte
    always_comb begin
        case (i_in_data.func)
            FUNC_RESTART: begin
                n_item.op   = OP_RESTART;
                n_item.data = 8'h00;
            end
            default: begin
                n_item.op   = OP_BYTE;
                n_item.data = i_in_data.rx_byte;
            end
        endcase
    end

    assign o_push      = r_valid && !i_queue_full;
    assign o_push_data = r_item;
    assign o_in_ready  = !r_valid || !i_queue_full;

    // Hold the item until the queue takes it
    always_comb begin
        n_valid = r_valid;
        if (o_push) begin
            n_valid = 1'b0;
        end
        if (i_in_valid && o_in_ready) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item <= n_item;
        end
    end

endmodule

// File: hdl/mfr_queue.sv
// Short queue between the front end and the frame engine.
// Depends on mfr_pkg for the item type and depth.
module mfr_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mfr_pkg::t_op_item i_push_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output mfr_pkg::t_op_item o_data
);
    import mfr_pkg::*;

    t_op_item              r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr;
    logic [QUEUE_AW:0]     r_count;
    logic [QUEUE_AW:0]     n_count;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Track fill level
    always_comb begin
        n_count = r_count;
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// File: hdl/mfr_engine.sv
// Frame engine of the MQTT frame receiver: header decode, length varint,
// body pass-through, end-of-frame check and output register. Uses mfr_pkg.
module mfr_engine #(
    parameter int LENGTH_GROUPS = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  mfr_pkg::t_op_item  i_q_data,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output mfr_pkg::t_out_item o_out_data
);
    import mfr_pkg::*;

    typedef enum logic [2:0] {
        PH_TYPE = 3'b001,
        PH_LEN  = 3'b010,
        PH_BODY = 3'b100
    } t_phase;

    typedef enum logic [2:0] {
        LK_WAIT = 3'b001,
        LK_CONN = 3'b010,
        LK_ERR  = 3'b100
    } t_link;

    typedef struct packed {
        logic [2:0] status;
        t_link      link;
    } t_fin;

    t_link       r_link,  n_link;
    t_phase      r_phase, n_phase;
    logic [3:0]  r_type,  n_type;
    logic [3:0]  r_flags, n_flags;
    logic [27:0] r_accum, n_accum;
    logic [2:0]  r_grp,   n_grp;
    logic [27:0] r_body,  n_body;
    logic [7:0]  r_code,  n_code;

    logic        r_out_valid;
    t_out_item   r_out, n_out;

    logic [27:0] len_term;
    logic [27:0] accum_sum;
    logic [27:0] body_inc;
    t_fin        fin;
    logic [7:0]  b;

    // Check a completed frame against the link state
    function automatic t_fin finish_frame(input logic [3:0] ptype, input t_link link,
                                          input logic [27:0] accum, input logic [7:0] code);
        t_fin f;
        f.status = ST_OK;
        f.link   = link;
        case (ptype)
            PKT_CONNACK: begin
                if (link != LK_WAIT) begin
                    f.status = ST_BAD_STATE;
                end else if (accum < 28'd2) begin
                    f.status = ST_MALFORMED;
                end else if (code != 8'h00) begin
                    f.status = ST_REFUSED;
                end else begin
                    f.link = LK_CONN;
                end
            end
            PKT_PUBLISH: begin
                if (link != LK_CONN) begin
                    f.status = ST_BAD_STATE;
                end
            end
            PKT_PUBACK, PKT_PUBREC, PKT_PUBREL, PKT_PUBCOMP,
            PKT_SUBACK, PKT_UNSUBACK, PKT_PINGRESP: begin
                f.status = ST_OK;
            end
            default: f.status = ST_UNEXPECTED;
        endcase
        if (f.status != ST_OK) begin
            f.link = LK_ERR;
        end
        return f;
    endfunction

    function automatic logic [1:0] link_code(input t_link link);
        case (link)
            LK_CONN: return LS_CONN;
            LK_ERR:  return LS_ERR;
            default: return LS_WAIT;
        endcase
    endfunction

    assign b     = i_q_data.data;
    assign o_pop = i_q_valid && (!r_out_valid || i_out_ready);

    // Place the 7-bit length group at its weight
    always_comb begin
        case (r_grp[1:0])
            2'd1:    len_term = {14'd0, b[6:0] & LEN_DATA_MASK[6:0], 7'd0};
            2'd2:    len_term = {7'd0, b[6:0] & LEN_DATA_MASK[6:0], 14'd0};
            2'd3:    len_term = {b[6:0] & LEN_DATA_MASK[6:0], 21'd0};
            default: len_term = {21'd0, b[6:0] & LEN_DATA_MASK[6:0]};
        endcase
    end

    assign accum_sum = r_accum + len_term;
    assign body_inc  = r_body + 28'd1;

    // End-of-frame check, fed by whichever phase completes the frame
    always_comb begin
        if (r_phase == PH_BODY) begin
            fin = finish_frame(r_type, r_link, r_accum,
                               (body_inc == 28'd2) ? b : r_code);
        end else begin
            fin = finish_frame(r_type, r_link, accum_sum, r_code);
        end
    end

    // Advance the frame state for one item
    always_comb begin
        logic [1:0] ev;
        logic [7:0] bo;
        logic       fend;
        logic [2:0] st;

        n_link  = r_link;
        n_phase = r_phase;
        n_type  = r_type;
        n_flags = r_flags;
        n_accum = r_accum;
        n_grp   = r_grp;
        n_body  = r_body;
        n_code  = r_code;
        ev      = EV_HEADER;
        bo      = 8'h00;
        fend    = 1'b0;
        st      = ST_OK;

        if (i_q_data.op == OP_RESTART) begin
            n_link  = LK_WAIT;
            n_phase = PH_TYPE;
            n_type  = 4'd0;
            n_flags = 4'd0;
            n_accum = 28'd0;
            n_grp   = 3'd0;
            n_body  = 28'd0;
            n_code  = 8'h00;
            ev      = EV_RESTART;
        end else if (r_link == LK_ERR) begin
            ev = EV_DROP;
            st = ST_BAD_STATE;
        end else begin
            case (r_phase)
                PH_LEN: begin
                    if (r_grp >= 3'(LENGTH_GROUPS)) begin
                        st      = ST_MALFORMED;
                        n_link  = LK_ERR;
                        n_phase = PH_TYPE;
                    end else begin
                        n_accum = accum_sum;
                        n_grp   = r_grp + 3'd1;
                        if ((b & LEN_MORE_BIT) == 8'h00) begin
                            if (accum_sum == 28'd0) begin
                                fend    = 1'b1;
                                st      = fin.status;
                                n_link  = fin.link;
                                n_phase = PH_TYPE;
                            end else begin
                                n_phase = PH_BODY;
                            end
                        end
                    end
                end
                PH_BODY: begin
                    ev     = EV_BODY;
                    bo     = b;
                    n_body = body_inc;
                    if (body_inc == 28'd2) begin
                        n_code = b;
                    end
                    if (body_inc >= r_accum) begin
                        fend    = 1'b1;
                        st      = fin.status;
                        n_link  = fin.link;
                        n_phase = PH_TYPE;
                    end
                end
                default: begin
                    n_type  = b[7:4];
                    n_flags = b[3:0] & NIBBLE_MASK;
                    n_accum = 28'd0;
                    n_grp   = 3'd0;
                    n_body  = 28'd0;
                    n_code  = 8'h00;
                    n_phase = PH_LEN;
                end
            endcase
        end

        n_out.event_res   = ev;
        n_out.byte_out    = bo;
        n_out.frame_type  = n_type;
        n_out.frame_flags = n_flags;
        n_out.body_length = n_accum;
        n_out.frame_end   = fend;
        n_out.status      = st;
        n_out.link_state  = link_code(n_link);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link      <= LK_WAIT;
            r_phase     <= PH_TYPE;
            r_type      <= 4'd0;
            r_flags     <= 4'd0;
            r_accum     <= 28'd0;
            r_grp       <= 3'd0;
            r_body      <= 28'd0;
            r_code      <= 8'h00;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_link  <= n_link;
                r_phase <= n_phase;
                r_type  <= n_type;
                r_flags <= n_flags;
                r_accum <= n_accum;
                r_grp   <= n_grp;
                r_body  <= n_body;
                r_code  <= n_code;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output register holds while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: hdl/mqtt_frame_receiver.sv
// MQTT frame receiver top level: deframes a received byte stream.
// Instantiates mfr_front, mfr_queue and mfr_engine; uses mfr_pkg.
//
// Input channel (i_in_valid / o_in_ready / i_in_data): one item per
// transaction, either a received byte or a restart request.
// Output channel (o_out_valid / i_out_ready / o_out_data): exactly one result
// per input item, in order: event code, passed-through body byte, held frame
// type and flags, decoded remaining length, end-of-frame mark, status and
// link state.
// Path: each item passes through the input register, the queue and the output
// register before its result shows on the output.
// Throughput: one item per cycle while the receiver keeps taking results; the
// frame engine settles each byte in one combinational update of its state.
// A four-entry queue separates the front end from the engine, so the input
// keeps accepting while a result waits; when the receiver stalls, the output
// holds, the queue fills and o_in_ready then drops.
// Reset (i_rst_n low, synchronous) empties the queue and the output register
// and puts the link into waiting-for-connack with the frame phase expecting
// a type byte.
module mqtt_frame_receiver #(
    parameter int LENGTH_GROUPS = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  mfr_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output mfr_pkg::t_out_item o_out_data
);
    import mfr_pkg::*;

    logic     push;
    t_op_item push_data;
    logic     queue_full;
    logic     pop;
    logic     q_valid;
    t_op_item q_data;

    mfr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .o_push       (push),
        .o_push_data  (push_data),
        .i_queue_full (queue_full)
    );

    mfr_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (queue_full),
        .i_pop       (pop),
        .o_valid     (q_valid),
        .o_data      (q_data)
    );

    mfr_engine #(
        .LENGTH_GROUPS (LENGTH_GROUPS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_data    (q_data),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// File: hdl/mfr_checker.sv
// Port-level checks for the MQTT frame receiver, bound to the top level.
// Uses mfr_pkg for result codes.
module mfr_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input mfr_pkg::t_out_item o_out_data
);
    import mfr_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // Restart reports a clean waiting link
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.event_res == EV_RESTART |->
            o_out_data.link_state == LS_WAIT && o_out_data.status == ST_OK &&
            o_out_data.frame_end == 1'b0 && o_out_data.body_length == 28'd0)
        else $error("restart result not clean");

    // Dropped bytes only in the error state
    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.event_res == EV_DROP |->
            o_out_data.status == ST_BAD_STATE && o_out_data.link_state == LS_ERR)
        else $error("drop outside error state");

    // Any error leaves the link in error
    a_err_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ST_OK |-> o_out_data.link_state == LS_ERR)
        else $error("error status without error link");

    // Frame end only on header or body bytes
    a_fend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.frame_end |->
            o_out_data.event_res == EV_HEADER || o_out_data.event_res == EV_BODY)
        else $error("frame end on wrong event");

endmodule

bind mqtt_frame_receiver mfr_checker u_mfr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
